/* rtl/core/bps_pkg.sv */
// Shared types and constants for the bplist17 leading-string parser.
package bps_pkg;

    // "bplist17", first byte in the low bits
    localparam logic [63:0] MAGIC_BYTES = 64'h3731_7473_696C_7062;

    localparam logic [7:0] ROOT_ARRAY_TAG = 8'hA0;
    localparam logic [3:0] ASCII_TAG_HI   = 4'h7;
    localparam logic [3:0] INT_TAG_HI     = 4'h1;
    localparam logic [3:0] LONG_FORM_LO   = 4'hF;
    localparam logic [3:0] MAX_LEN_WIDTH  = 4'd8;

    typedef logic [2:0] result_code_t;

    localparam result_code_t RC_OK    = 3'd0;
    localparam result_code_t RC_TRUNC = 3'd1;
    localparam result_code_t RC_MAGIC = 3'd2;
    localparam result_code_t RC_ROOT  = 3'd3;
    localparam result_code_t RC_STAG  = 3'd4;
    localparam result_code_t RC_LTAG  = 3'd5;
    localparam result_code_t RC_WIDTH = 3'd6;
    localparam result_code_t RC_ZERO  = 3'd7;

    typedef struct packed {
        logic [7:0]   sel_char;
        logic         status_item;
        result_code_t result_code;
    } bps_res_t;

endpackage

/* rtl/core/bps_parse.sv */
// Parse state and per-byte decode: turns one registered byte into up to two result items.
module bps_parse (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    output bps_pkg::bps_res_t  res_a,
    output bps_pkg::bps_res_t  res_b,
    output logic [1:0]         res_cnt
);

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_ROOT,
        PH_SKIP,
        PH_STAG,
        PH_LTAG,
        PH_LBYTES,
        PH_STR,
        PH_DONE,
        PH_ERR
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [3:0]            step_count_reg, step_count_next;
    logic [3:0]            width_left_reg, width_left_next;
    logic [63:0]           str_length_reg, str_length_next;
    logic [63:0]           bytes_left_reg, bytes_left_next;
    bps_pkg::result_code_t err_code_reg, err_code_next;

    logic                  emit_char;
    logic [63:0]           len_acc;
    logic [63:0]           left_dec;
    bps_pkg::result_code_t status_code;
    bps_pkg::bps_res_t     char_res;
    bps_pkg::bps_res_t     stat_res;

    always_comb begin
        phase_next      = phase_reg;
        step_count_next = step_count_reg;
        width_left_next = width_left_reg;
        str_length_next = str_length_reg;
        bytes_left_next = bytes_left_reg;
        err_code_next   = err_code_reg;
        emit_char       = 1'b0;
        len_acc         = str_length_reg | ({56'd0, data_byte} << {step_count_reg[2:0], 3'b000});
        left_dec        = bytes_left_reg - 64'd1;
        status_code     = bps_pkg::RC_OK;

        case (phase_reg)
            PH_MAGIC: begin
                if (data_byte != bps_pkg::MAGIC_BYTES[{step_count_reg[2:0], 3'b000} +: 8]) begin
                    phase_next    = PH_ERR;
                    err_code_next = bps_pkg::RC_MAGIC;
                end else if (step_count_reg >= 4'd7) begin
                    step_count_next = 4'd0;
                    phase_next      = PH_ROOT;
                end else begin
                    step_count_next = step_count_reg + 4'd1;
                end
            end
            PH_ROOT: begin
                if (data_byte != bps_pkg::ROOT_ARRAY_TAG) begin
                    phase_next    = PH_ERR;
                    err_code_next = bps_pkg::RC_ROOT;
                end else begin
                    step_count_next = 4'd0;
                    phase_next      = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (step_count_reg >= 4'd7) begin
                    step_count_next = 4'd0;
                    phase_next      = PH_STAG;
                end else begin
                    step_count_next = step_count_reg + 4'd1;
                end
            end
            PH_STAG: begin
                if (data_byte[7:4] != bps_pkg::ASCII_TAG_HI) begin
                    phase_next    = PH_ERR;
                    err_code_next = bps_pkg::RC_STAG;
                end else if (data_byte[3:0] == bps_pkg::LONG_FORM_LO) begin
                    phase_next = PH_LTAG;
                end else if (data_byte[3:0] == 4'd0) begin
                    phase_next    = PH_ERR;
                    err_code_next = bps_pkg::RC_ZERO;
                end else begin
                    str_length_next = {60'd0, data_byte[3:0]};
                    bytes_left_next = {60'd0, data_byte[3:0]};
                    phase_next      = PH_STR;
                end
            end
            PH_LTAG: begin
                if (data_byte[7:4] != bps_pkg::INT_TAG_HI) begin
                    phase_next    = PH_ERR;
                    err_code_next = bps_pkg::RC_LTAG;
                end else if (data_byte[3:0] == 4'd0 ||
                             data_byte[3:0] > bps_pkg::MAX_LEN_WIDTH) begin
                    phase_next    = PH_ERR;
                    err_code_next = bps_pkg::RC_WIDTH;
                end else begin
                    width_left_next = data_byte[3:0];
                    step_count_next = 4'd0;
                    str_length_next = 64'd0;
                    phase_next      = PH_LBYTES;
                end
            end
            PH_LBYTES: begin
                // accumulate little-endian length, one byte lane per step
                str_length_next = len_acc;
                step_count_next = step_count_reg + 4'd1;
                width_left_next = width_left_reg - 4'd1;
                if (width_left_next == 4'd0) begin
                    step_count_next = 4'd0;
                    if (len_acc == 64'd0) begin
                        phase_next    = PH_ERR;
                        err_code_next = bps_pkg::RC_ZERO;
                    end else begin
                        bytes_left_next = len_acc;
                        phase_next      = PH_STR;
                    end
                end
            end
            PH_STR: begin
                // drop the terminator, pass everything before it
                emit_char       = (bytes_left_reg > 64'd1);
                bytes_left_next = left_dec;
                if (left_dec == 64'd0) begin
                    phase_next = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (final_byte) begin
            if (phase_next == PH_ERR) begin
                status_code = err_code_next;
            end else if (phase_next == PH_DONE) begin
                status_code = bps_pkg::RC_OK;
            end else begin
                status_code = bps_pkg::RC_TRUNC;
            end
            phase_next      = PH_MAGIC;
            step_count_next = 4'd0;
            width_left_next = 4'd0;
            str_length_next = 64'd0;
            bytes_left_next = 64'd0;
            err_code_next   = bps_pkg::RC_OK;
        end
    end

    always_comb begin
        char_res.sel_char    = data_byte;
        char_res.status_item = 1'b0;
        char_res.result_code = bps_pkg::RC_OK;
        stat_res.sel_char    = 8'd0;
        stat_res.status_item = 1'b1;
        stat_res.result_code = status_code;
        res_a   = emit_char ? char_res : stat_res;
        res_b   = stat_res;
        res_cnt = {1'b0, emit_char} + {1'b0, final_byte};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_MAGIC;
            step_count_reg <= 4'd0;
            width_left_reg <= 4'd0;
            str_length_reg <= 64'd0;
            bytes_left_reg <= 64'd0;
            err_code_reg   <= bps_pkg::RC_OK;
        end else if (fire) begin
            phase_reg      <= phase_next;
            step_count_reg <= step_count_next;
            width_left_reg <= width_left_next;
            str_length_reg <= str_length_next;
            bytes_left_reg <= bytes_left_next;
            err_code_reg   <= err_code_next;
        end
    end

endmodule

/* rtl/core/bps_out_fifo.sv */
// Four-entry result queue: takes up to two items per cycle, hands out one.
module bps_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_cnt,
    input  bps_pkg::bps_res_t  push_a,
    input  bps_pkg::bps_res_t  push_b,
    output logic               can_push,
    output logic               m_valid,
    input  logic               m_ready,
    output bps_pkg::bps_res_t  head
);

    bps_pkg::bps_res_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign m_valid  = (count_reg != 3'd0);
    assign pop      = m_valid && m_ready;
    assign head     = entry_reg[rd_ptr_reg];
    // room for two whatever the consumer does this cycle
    assign can_push = (count_reg <= 3'd2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/bplist_selector_parser.sv */
// Top level of the bplist17 leading-string parser: input register, decode, result queue.
//
// Streams a binary property list in, one byte per item, with s_final_byte set on
// the last byte of a buffer. The block checks the "bplist17" magic and the 0xA0
// array tag, skips the eight offset bytes, reads the ASCII string tag (short
// length in the low nibble, or a 0x1w integer tag and w little-endian length
// bytes), and then emits each string character as its own item, leaving out
// the terminator. The final byte always adds one status item (m_status_item = 1)
// with the result code; the first error found wins, and characters already sent
// must be discarded by the consumer unless that code is ok. Bytes after the
// string are ignored, and the parser restarts after every final byte.
// Rate: one byte per cycle sustained while the result queue has room for two and
// the output keeps up. A byte is held in the input register and decoded, and its
// results are written into a four-entry result queue that offers them on the output
// (m_valid high); a result can leave once the queue holds it. A final byte that also
// carries a character produces two results, which the single-item output port
// hands out one at a time; the queue depth sets how long the input keeps flowing
// while the output is stalled.
module bplist_selector_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_sel_char,
    output logic       m_status_item,
    output logic [2:0] m_result_code
);

    logic              in_valid_reg;
    logic [7:0]        data_reg;
    logic              final_reg;
    logic              fire;
    logic              can_push;
    logic [1:0]        res_cnt;
    logic [1:0]        push_cnt;
    bps_pkg::bps_res_t res_a;
    bps_pkg::bps_res_t res_b;
    bps_pkg::bps_res_t head;

    // Advance the held byte into the decoder when the queue has room for two.
    assign fire     = in_valid_reg && can_push;
    assign s_ready  = !in_valid_reg || fire;
    assign push_cnt = fire ? res_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Hold payload only; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg  <= s_data_byte;
            final_reg <= s_final_byte;
        end
    end

    bps_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .data_byte  (data_reg),
        .final_byte (final_reg),
        .res_a      (res_a),
        .res_b      (res_b),
        .res_cnt    (res_cnt)
    );

    bps_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push_a   (res_a),
        .push_b   (res_b),
        .can_push (can_push),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_sel_char    = head.sel_char;
    assign m_status_item = head.status_item;
    assign m_result_code = head.result_code;

endmodule

/* test/bplist_selector_parser_check.sv */
// Scoreboard for the bplist17 leading-string parser: tracks accepted bytes and checks each result.
module bplist_selector_parser_check (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_sel_char,
    input  logic       m_status_item,
    input  logic [2:0] m_result_code,
    output int         fail_count,
    output int         pending,
    output int         char_count,
    output logic [7:0] codes_seen
);

    typedef enum logic [3:0] {
        ST_MAGIC,
        ST_ROOT,
        ST_SKIP,
        ST_STAG,
        ST_LTAG,
        ST_LBYTES,
        ST_STR,
        ST_DONE,
        ST_ERR
    } parse_phase_t;

    parse_phase_t          phase;
    logic [3:0]            step_cnt;
    logic [3:0]            width_left;
    logic [63:0]           str_len;
    logic [63:0]           bytes_left;
    bps_pkg::result_code_t err_code;
    bps_pkg::bps_res_t     expect_q[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        char_count = 0;
        codes_seen = '0;
    end

    function automatic void clear_parse();
        phase      = ST_MAGIC;
        step_cnt   = '0;
        width_left = '0;
        str_len    = '0;
        bytes_left = '0;
        err_code   = bps_pkg::RC_OK;
    endfunction

    function automatic void flag_error(input bps_pkg::result_code_t code);
        phase    = ST_ERR;
        err_code = code;
    endfunction

    // A zero length is an error as soon as it is known.
    function automatic void open_string(input logic [63:0] len);
        if (len == 64'd0) begin
            flag_error(bps_pkg::RC_ZERO);
        end else begin
            str_len    = len;
            bytes_left = len;
            phase      = ST_STR;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        bps_pkg::bps_res_t     res;
        bps_pkg::result_code_t code;
        case (phase)
            ST_MAGIC: begin
                if (b != bps_pkg::MAGIC_BYTES[8*step_cnt[2:0] +: 8]) begin
                    flag_error(bps_pkg::RC_MAGIC);
                end else if (step_cnt >= 4'd7) begin
                    step_cnt = '0;
                    phase    = ST_ROOT;
                end else begin
                    step_cnt = step_cnt + 4'd1;
                end
            end
            ST_ROOT: begin
                if (b != bps_pkg::ROOT_ARRAY_TAG) begin
                    flag_error(bps_pkg::RC_ROOT);
                end else begin
                    step_cnt = '0;
                    phase    = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (step_cnt >= 4'd7) begin
                    step_cnt = '0;
                    phase    = ST_STAG;
                end else begin
                    step_cnt = step_cnt + 4'd1;
                end
            end
            ST_STAG: begin
                if (b[7:4] != bps_pkg::ASCII_TAG_HI) begin
                    flag_error(bps_pkg::RC_STAG);
                end else if (b[3:0] == bps_pkg::LONG_FORM_LO) begin
                    phase = ST_LTAG;
                end else begin
                    open_string(64'(b[3:0]));
                end
            end
            ST_LTAG: begin
                if (b[7:4] != bps_pkg::INT_TAG_HI) begin
                    flag_error(bps_pkg::RC_LTAG);
                end else if (b[3:0] == 4'd0 || b[3:0] > bps_pkg::MAX_LEN_WIDTH) begin
                    flag_error(bps_pkg::RC_WIDTH);
                end else begin
                    width_left = b[3:0];
                    step_cnt   = '0;
                    str_len    = '0;
                    phase      = ST_LBYTES;
                end
            end
            ST_LBYTES: begin
                // little-endian length
                str_len    = str_len | (64'(b) << (8 * step_cnt[2:0]));
                step_cnt   = step_cnt + 4'd1;
                width_left = width_left - 4'd1;
                if (width_left == 4'd0) begin
                    step_cnt = '0;
                    open_string(str_len);
                end
            end
            ST_STR: begin
                // the terminator is consumed silently
                if (bytes_left > 64'd1) begin
                    res = '{sel_char: b, status_item: 1'b0, result_code: bps_pkg::RC_OK};
                    expect_q = {expect_q, res};
                end
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 64'd0) begin
                    phase = ST_DONE;
                end
            end
            default: ;
        endcase

        if (fin) begin
            if (phase == ST_ERR) begin
                code = err_code;
            end else if (phase == ST_DONE) begin
                code = bps_pkg::RC_OK;
            end else begin
                code = bps_pkg::RC_TRUNC;
            end
            res = '{sel_char: 8'h00, status_item: 1'b1, result_code: code};
            expect_q = {expect_q, res};
            clear_parse();
        end
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_result();
        bps_pkg::bps_res_t want;
        if (expect_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got char %0h status %0b code %0d",
                     $time, m_sel_char, m_status_item, m_result_code);
            fail_count++;
        end else begin
            want = expect_q.pop_front();
            check_field("sel_char", want.sel_char, m_sel_char);
            check_field("status_item", 8'(want.status_item), 8'(m_status_item));
            check_field("result_code", 8'(want.result_code), 8'(m_result_code));
            if (want.status_item) begin
                codes_seen[want.result_code] = 1'b1;
            end else begin
                char_count++;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            expect_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_data_byte, s_final_byte);
            end
            if (m_valid && m_ready) begin
                compare_result();
            end
        end
        pending = expect_q.size();
    end

endmodule

/* test/bplist_selector_parser_test.sv */
// Stimulus and verdict for the bplist17 leading-string parser.
module bplist_selector_parser_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BYTES  = 210;
    localparam int IDLE_PCT      = 27;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_final_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_sel_char;
    logic       m_status_item;
    logic [2:0] m_result_code;

    int         fail_count;
    int         pending;
    int         char_count;
    logic [7:0] codes_seen;

    // calm = 1 turns off idling on both sides
    logic       calm;
    int         cycle_count;
    int         bytes_sent;
    int         frames_sent;
    logic [7:0] frame_q[$];

    bplist_selector_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sel_char    (m_sel_char),
        .m_status_item (m_status_item),
        .m_result_code (m_result_code)
    );

    bplist_selector_parser_check i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sel_char    (m_sel_char),
        .m_status_item (m_status_item),
        .m_result_code (m_result_code),
        .fail_count    (fail_count),
        .pending       (pending),
        .char_count    (char_count),
        .codes_seen    (codes_seen)
    );

    always #5 aclk = ~aclk;

    // Stall the result channel at random; ready may drop at any cycle.
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive one byte: idle some cycles with valid low, then hold valid and the
    // payload steady until the handshake completes. Valid is touched once per
    // falling edge, so back-to-back items keep it high without a glitch.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_final_byte <= fin;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Drop valid and hold off until every predicted result has drained.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Append one byte to the frame being assembled.
    task automatic add_byte(input logic [7:0] b);
        frame_q = {frame_q, b};
    endtask

    // Append magic, root array tag and eight offset bytes of random content.
    task automatic add_header();
        for (int i = 0; i < 8; i++) add_byte(bps_pkg::MAGIC_BYTES[8*i +: 8]);
        add_byte(bps_pkg::ROOT_ARRAY_TAG);
        for (int i = 0; i < 8; i++) add_byte(8'($urandom));
    endtask

    // Append the string tag; width 0 selects the short form.
    task automatic add_length(input logic [63:0] len, input int width);
        if (width == 0) begin
            add_byte({bps_pkg::ASCII_TAG_HI, len[3:0]});
        end else begin
            add_byte({bps_pkg::ASCII_TAG_HI, bps_pkg::LONG_FORM_LO});
            add_byte({bps_pkg::INT_TAG_HI, 4'(width)});
            for (int i = 0; i < width; i++) add_byte(len[8*i +: 8]);
        end
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) add_byte(8'($urandom));
    endtask

    // Send the assembled frame, flagging its last byte, then clear it.
    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) begin
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
        frame_q.delete();
        frames_sent++;
    endtask

    // Mostly well-formed frames with random content; the rest are cut short,
    // corrupted in the header, carry a wild long length, or are pure noise.
    task automatic random_frame();
        int          kind;
        int          len;
        int          width;
        int          pos;
        logic [63:0] wild;
        kind = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 12);
        add_header();
        if (len < 15 && $urandom_range(1) == 1) begin
            add_length(64'(len), 0);
        end else begin
            add_length(64'(len), $urandom_range(1, 8));
        end
        add_random(len);
        add_random($urandom_range(3));
        if (kind >= 60 && kind < 72) begin
            // truncate anywhere inside the frame
            pos = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > pos) void'(frame_q.pop_back());
        end else if (kind >= 72 && kind < 84) begin
            // corrupt a byte in the header, tags or length
            pos = $urandom_range((frame_q.size() > 21) ? 21 : frame_q.size() - 1);
            frame_q[pos] = 8'($urandom);
        end else if (kind >= 84 && kind < 92) begin
            // random long length, almost always truncated
            frame_q.delete();
            add_header();
            wild = {$urandom, $urandom};
            add_length(wild, $urandom_range(1, 8));
            add_random($urandom_range(12));
        end else if (kind >= 92) begin
            frame_q.delete();
            add_random($urandom_range(1, 20));
        end
        send_frame();
    endtask

    initial begin
        int random_start;
        int random_first;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = 8'h00;
        s_final_byte = 1'b0;
        m_ready      = 1'b0;
        calm         = 1'b0;
        cycle_count  = 0;
        bytes_sent   = 0;
        frames_sent  = 0;

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: short form ok, characters at both extremes, final on the terminator.
        add_header();
        add_length(64'd4, 0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h55);
        add_byte(8'hAA);
        send_frame();

        // Long form, width 1, with trailing bytes that must be ignored.
        add_header();
        add_length(64'd3, 1);
        add_random(3 + 2);
        send_frame();

        // Widest length field with small value.
        add_header();
        add_length(64'd2, 8);
        add_random(2);
        send_frame();

        // Length one: only a terminator, no characters.
        add_header();
        add_length(64'd1, 0);
        add_random(1);
        send_frame();

        // Zero length in short and long form.
        add_header();
        add_length(64'd0, 0);
        add_random(3);
        send_frame();
        add_header();
        add_length(64'd0, 2);
        add_random(2);
        send_frame();

        // Bad magic at the first and at the last magic byte.
        add_byte(8'h00);
        add_random(4);
        send_frame();
        add_header();
        frame_q[7] = 8'h38;
        send_frame();

        // Bad root tag; a valid-looking tail after it must not override the error.
        add_header();
        frame_q[8] = 8'hA1;
        add_length(64'd3, 0);
        add_random(3);
        send_frame();

        // Bad string tag, bad length tag, width zero and width nine.
        add_header();
        add_byte(8'h6F);
        send_frame();
        add_header();
        add_byte({bps_pkg::ASCII_TAG_HI, bps_pkg::LONG_FORM_LO});
        add_byte(8'h2F);
        send_frame();
        add_header();
        add_byte({bps_pkg::ASCII_TAG_HI, bps_pkg::LONG_FORM_LO});
        add_byte({bps_pkg::INT_TAG_HI, 4'h0});
        send_frame();
        add_header();
        add_byte({bps_pkg::ASCII_TAG_HI, bps_pkg::LONG_FORM_LO});
        add_byte({bps_pkg::INT_TAG_HI, 4'h9});
        send_frame();

        // One-byte frames: a good first magic byte truncates, a bad one errors.
        add_byte(bps_pkg::MAGIC_BYTES[7:0]);
        send_frame();
        add_byte(8'hFF);
        send_frame();

        // Truncated inside the offset bytes.
        add_header();
        repeat (5) void'(frame_q.pop_back());
        send_frame();

        // Final byte carries a character: character item, then a truncated status.
        add_header();
        add_length(64'd5, 0);
        add_random(4);
        send_frame();

        // Let everything drain before the random part.
        hold_until_drained();

        random_start = bytes_sent;
        random_first = frames_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            // one stretch with no idling on either side
            calm = (bytes_sent - random_start >= 30) && (bytes_sent - random_start < 130);
            if (frames_sent == random_first + 5) begin
                hold_until_drained();
            end
            random_frame();
        end
        calm = 1'b0;

        // Wait out the remaining results plus the pipeline depth.
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Ran %0d frames, %0d bytes; %0d string characters checked.",
                 frames_sent, bytes_sent, char_count);
        $display("Status codes returned, one bit per code with ok in bit 0: %08b",
                 codes_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
